FILE: hdl/plti_pkg.sv
`default_nettype none

package plti_pkg;

  localparam int MAX_SAMPLES_DEF = 256;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int CFG_WIDTH    = 9;
  localparam int INDEX_WIDTH  = 8;
  localparam int REGION_WIDTH = 2;

  localparam logic [CFG_WIDTH-1:0] SAMPLES_RESET = 9'd256;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [REGION_WIDTH-1:0] REGION_BELOW  = 2'd0;
  localparam logic [REGION_WIDTH-1:0] REGION_INSIDE = 2'd1;
  localparam logic [REGION_WIDTH-1:0] REGION_ABOVE  = 2'd2;

  // sequencer -> arithmetic unit
  typedef struct packed {
    logic start;
    logic anchor_hi;
  } plti_req_t;

  // arithmetic unit -> sequencer
  typedef struct packed {
    logic done;
    logic sat;
  } plti_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/piecewise_linear_table_interp_top.sv
// Load transaction: written at its accept edge; in_ready stays high.
// Query transaction: the end entries are read, the query is classified, the table is scanned
// one entry per cycle and the bracketing pair goes to the arithmetic unit; a zero-width segment
// returns the anchor value and a query on the last point bypasses the arithmetic.
// The arithmetic runs on the shared add/subtract unit (DATA_WIDTH multiply, 2*DATA_WIDTH divide
// steps). The next query is taken once the result is presented. Reset: control, 256 samples.
`default_nettype none

module piecewise_linear_table_interp_top #(
  parameter int MAX_SAMPLES = plti_pkg::MAX_SAMPLES_DEF,
  parameter int DATA_WIDTH  = plti_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [plti_pkg::CFG_WIDTH-1:0]    cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              kind,
  input  wire logic [plti_pkg::INDEX_WIDTH-1:0]  entry_index,
  input  wire logic [DATA_WIDTH-1:0]             sample_point,
  input  wire logic [DATA_WIDTH-1:0]             sample_value,
  input  wire logic [DATA_WIDTH-1:0]             query_point,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [DATA_WIDTH-1:0]             interp_value,
  output logic      [plti_pkg::REGION_WIDTH-1:0] region,
  output logic                                   saturated
);

  import plti_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);

  logic [CFG_WIDTH-1:0]    samples_in_use;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic [2*DATA_WIDTH-1:0] mem_wdata, mem_rdata;
  logic [DATA_WIDTH-1:0]   lo_point, lo_value, hi_point, hi_value, q_point;
  logic [DATA_WIDTH-1:0]   arith_value;
  plti_req_t               arith_req;
  plti_rsp_t               arith_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_in_use <= SAMPLES_RESET;
    end else if (cfg_wr_en) begin
      samples_in_use <= cfg_wr_data;
    end
  end

  plti_mem #(
    .DEPTH (MAX_SAMPLES),
    .WIDTH (2 * DATA_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  plti_arith #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_arith (
    .clk      (clk),
    .rst      (rst),
    .req      (arith_req),
    .lo_point (lo_point),
    .lo_value (lo_value),
    .hi_point (hi_point),
    .hi_value (hi_value),
    .q_point  (q_point),
    .rsp      (arith_rsp),
    .value    (arith_value)
  );

  plti_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .entry_index    (entry_index),
    .sample_point   (sample_point),
    .sample_value   (sample_value),
    .query_point    (query_point),
    .samples_in_use (samples_in_use),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .interp_value   (interp_value),
    .region         (region),
    .saturated      (saturated),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata),
    .lo_point       (lo_point),
    .lo_value       (lo_value),
    .hi_point       (hi_point),
    .hi_value       (hi_value),
    .q_point        (q_point),
    .arith_req      (arith_req),
    .arith_rsp      (arith_rsp),
    .arith_value    (arith_value)
  );

  // a query occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_QUERY |=> !in_ready)
    else $error("in_ready high right after a query was accepted");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_LOAD && !out_valid |=> !out_valid)
    else $error("result appeared after a load");

  // a new result frees the input side in the same cycle
  a_result_frees: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result presented while sequencer still busy");

endmodule

`default_nettype wire

FILE: hdl/plti_mem.sv
`default_nettype none

module plti_mem #(
  parameter int DEPTH = plti_pkg::MAX_SAMPLES_DEF,
  parameter int WIDTH = 2 * plti_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/plti_arith.sv
`default_nettype none

// Shared (DATA_WIDTH+1)-bit add/subtract unit, sequenced through:
// segment differences, shift-add multiply, restoring divide, final add.
module plti_arith #(
  parameter int DATA_WIDTH = plti_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire plti_pkg::plti_req_t   req,
  input  wire logic [DATA_WIDTH-1:0] lo_point,
  input  wire logic [DATA_WIDTH-1:0] lo_value,
  input  wire logic [DATA_WIDTH-1:0] hi_point,
  input  wire logic [DATA_WIDTH-1:0] hi_value,
  input  wire logic [DATA_WIDTH-1:0] q_point,
  output plti_pkg::plti_rsp_t        rsp,
  output logic      [DATA_WIDTH-1:0] value
);

  import plti_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int CW = $clog2(2 * DW);
  localparam logic [DW-1:0] SIGN_BIT = {1'b1, {(DW-1){1'b0}}};

  localparam logic [1:0] DIFF_DY = 2'd0;
  localparam logic [1:0] DIFF_DQ = 2'd1;
  localparam logic [1:0] DIFF_DX = 2'd2;

  typedef enum logic [6:0] {
    A_IDLE  = 7'b0000001,
    A_DIFF  = 7'b0000010,
    A_CHECK = 7'b0000100,
    A_MUL   = 7'b0001000,
    A_DIV   = 7'b0010000,
    A_FIN   = 7'b0100000,
    A_DONE  = 7'b1000000
  } astate_t;

  astate_t state, state_next;

  logic [1:0]      sel;
  logic            swap;
  logic [CW-1:0]   cnt;
  logic [DW-1:0]   dy_mag;
  logic [DW-1:0]   dx_mag;
  logic            ny, nq, nx;
  logic [2*DW-1:0] prod;
  logic [DW-1:0]   rem;
  logic            sat;

  logic [DW-1:0]   anchor, anchor_point;
  logic [DW-1:0]   opnd_first, opnd_second;
  logic [DW:0]     add_a, add_b, sum;
  logic            add_sub;
  logic [DW:0]     shifted;
  logic            take;
  logic            neg;
  logic            fin_sat;

  function automatic logic [DW-1:0] flip(input logic [DW-1:0] x);
    return x ^ SIGN_BIT;
  endfunction

  assign anchor       = req.anchor_hi ? hi_value : lo_value;
  assign anchor_point = req.anchor_hi ? hi_point : lo_point;
  assign neg          = ny ^ nq ^ nx;
  assign shifted      = {rem, prod[2*DW-1]};
  assign take         = ~sum[DW];
  assign fin_sat      = (|prod[2*DW-1:DW]) | sum[DW];

  always_comb begin
    case (sel)
      DIFF_DY: begin
        opnd_first  = hi_value;
        opnd_second = lo_value;
      end
      DIFF_DQ: begin
        opnd_first  = q_point;
        opnd_second = anchor_point;
      end
      default: begin
        opnd_first  = hi_point;
        opnd_second = lo_point;
      end
    endcase
  end

  // operand select for the one shared adder
  always_comb begin
    case (state)
      A_DIFF: begin
        add_a   = {1'b0, flip(swap ? opnd_second : opnd_first)};
        add_b   = {1'b0, flip(swap ? opnd_first : opnd_second)};
        add_sub = 1'b1;
      end
      A_MUL: begin
        add_a   = {1'b0, prod[2*DW-1:DW]};
        add_b   = prod[0] ? {1'b0, dy_mag} : '0;
        add_sub = 1'b0;
      end
      A_DIV: begin
        add_a   = shifted;
        add_b   = {1'b0, dx_mag};
        add_sub = 1'b1;
      end
      A_FIN: begin
        add_a   = {1'b0, flip(anchor)};
        add_b   = {1'b0, prod[DW-1:0]};
        add_sub = neg;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
      end
    endcase
  end

  assign sum = add_sub ? (add_a - add_b) : (add_a + add_b);

  always_comb begin
    state_next = state;
    case (state)
      A_IDLE:  if (req.start) state_next = A_DIFF;
      A_DIFF:  if ((swap || !sum[DW]) && sel == DIFF_DX) state_next = A_CHECK;
      A_CHECK: state_next = (dx_mag == '0) ? A_DONE : A_MUL;
      A_MUL:   if (cnt == CW'(DW - 1)) state_next = A_DIV;
      A_DIV:   if (cnt == CW'(2 * DW - 1)) state_next = A_FIN;
      A_FIN:   state_next = A_DONE;
      A_DONE:  state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      A_IDLE: begin
        sel  <= DIFF_DY;
        swap <= 1'b0;
      end
      A_DIFF: begin
        if (!swap && sum[DW]) begin
          // a < b: redo as b - a for the magnitude
          swap <= 1'b1;
        end else begin
          swap <= 1'b0;
          sel  <= sel + 2'd1;
          case (sel)
            DIFF_DY: begin
              dy_mag <= sum[DW-1:0];
              ny     <= swap;
            end
            DIFF_DQ: begin
              prod[DW-1:0] <= sum[DW-1:0];
              nq           <= swap;
            end
            default: begin
              dx_mag <= sum[DW-1:0];
              nx     <= swap;
            end
          endcase
        end
      end
      A_CHECK: begin
        prod[2*DW-1:DW] <= '0;
        cnt             <= '0;
        if (dx_mag == '0) begin
          value <= anchor;
          sat   <= 1'b0;
        end
      end
      A_MUL: begin
        prod <= {sum, prod[DW-1:1]};
        cnt  <= (cnt == CW'(DW - 1)) ? '0 : cnt + CW'(1);
        rem  <= '0;
      end
      A_DIV: begin
        rem  <= take ? sum[DW-1:0] : shifted[DW-1:0];
        prod <= {prod[2*DW-2:0], take};
        cnt  <= cnt + CW'(1);
      end
      A_FIN: begin
        sat <= fin_sat;
        if (fin_sat) begin
          value <= neg ? SIGN_BIT : ~SIGN_BIT;
        end else begin
          value <= flip(sum[DW-1:0]);
        end
      end
      default: ;
    endcase
  end

  assign rsp = '{done: (state == A_DONE), sat: sat};

endmodule

`default_nettype wire

FILE: hdl/plti_ctrl.sv
`default_nettype none

// Query sequencer: reads end entries, classifies, scans one entry per cycle,
// hands the bracketing pair to the arithmetic unit and holds the result.
module plti_ctrl #(
  parameter int MAX_SAMPLES = plti_pkg::MAX_SAMPLES_DEF,
  parameter int DATA_WIDTH  = plti_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             kind,
  input  wire logic [plti_pkg::INDEX_WIDTH-1:0] entry_index,
  input  wire logic [DATA_WIDTH-1:0]            sample_point,
  input  wire logic [DATA_WIDTH-1:0]            sample_value,
  input  wire logic [DATA_WIDTH-1:0]            query_point,
  input  wire logic [plti_pkg::CFG_WIDTH-1:0]   samples_in_use,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [DATA_WIDTH-1:0]            interp_value,
  output logic      [plti_pkg::REGION_WIDTH-1:0] region,
  output logic                                  saturated,
  output logic                                  mem_we,
  output logic      [$clog2(MAX_SAMPLES)-1:0]   mem_waddr,
  output logic      [2*DATA_WIDTH-1:0]          mem_wdata,
  output logic      [$clog2(MAX_SAMPLES)-1:0]   mem_raddr,
  input  wire logic [2*DATA_WIDTH-1:0]          mem_rdata,
  output logic      [DATA_WIDTH-1:0]            lo_point,
  output logic      [DATA_WIDTH-1:0]            lo_value,
  output logic      [DATA_WIDTH-1:0]            hi_point,
  output logic      [DATA_WIDTH-1:0]            hi_value,
  output logic      [DATA_WIDTH-1:0]            q_point,
  output plti_pkg::plti_req_t                   arith_req,
  input  wire plti_pkg::plti_rsp_t              arith_rsp,
  input  wire logic [DATA_WIDTH-1:0]            arith_value
);

  import plti_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int AW = $clog2(MAX_SAMPLES);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RD0    = 9'b000000010,
    S_RDL    = 9'b000000100,
    S_BELOW  = 9'b000001000,
    S_ABOVE  = 9'b000010000,
    S_SEARCH = 9'b000100000,
    S_START  = 9'b001000000,
    S_ARITH  = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [AW-1:0]           idx;
  logic [AW-1:0]           last_idx;
  logic [AW-1:0]           last_calc;
  logic                    anchor_hi;
  logic [DW-1:0]           res_value;
  logic                    res_sat;
  logic [REGION_WIDTH-1:0] res_region;

  logic [DW-1:0] rd_point, rd_value;
  logic          q_lt_lo, q_lt_rd, q_gt_rd;
  logic          query_acc;
  logic          out_load;

  assign rd_point = mem_rdata[2*DW-1:DW];
  assign rd_value = mem_rdata[DW-1:0];

  assign q_lt_lo = $signed(q_point) < $signed(lo_point);
  assign q_lt_rd = $signed(q_point) < $signed(rd_point);
  assign q_gt_rd = $signed(q_point) > $signed(rd_point);

  assign in_ready  = (state == S_IDLE);
  assign query_acc = in_valid && in_ready && (kind == KIND_QUERY);
  assign out_load  = (state == S_FIN) && (!out_valid || out_ready);

  // loads write straight through; out-of-range indexes are dropped
  assign mem_we    = in_valid && in_ready && (kind == KIND_LOAD)
                     && (int'(entry_index) < MAX_SAMPLES);
  assign mem_waddr = AW'(entry_index);
  assign mem_wdata = {sample_point, sample_value};

  // count clamped to [2, MAX_SAMPLES], as an index of the last entry
  always_comb begin
    if (samples_in_use < CFG_WIDTH'(2)) begin
      last_calc = AW'(1);
    end else if (int'(samples_in_use) > MAX_SAMPLES) begin
      last_calc = AW'(MAX_SAMPLES - 1);
    end else begin
      last_calc = AW'(samples_in_use - CFG_WIDTH'(1));
    end
  end

  // address for data seen in the next state; below the table wins over above
  always_comb begin
    case (state)
      S_RD0:    mem_raddr = last_idx;
      S_RDL:    mem_raddr = (!q_lt_lo && q_gt_rd) ? last_idx - AW'(1) : AW'(1);
      S_SEARCH: mem_raddr = idx + AW'(1);
      default:  mem_raddr = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (query_acc) state_next = S_RD0;
      S_RD0:    state_next = S_RDL;
      S_RDL: begin
        if (q_lt_lo) begin
          state_next = S_BELOW;
        end else if (q_gt_rd) begin
          state_next = S_ABOVE;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_BELOW:  state_next = S_START;
      S_ABOVE:  state_next = S_START;
      S_SEARCH: begin
        if (q_lt_rd) begin
          state_next = S_START;
        end else if (idx == last_idx) begin
          state_next = S_FIN;
        end
      end
      S_START:  state_next = S_ARITH;
      S_ARITH:  if (arith_rsp.done) state_next = S_FIN;
      S_FIN:    if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (query_acc) begin
          q_point  <= query_point;
          last_idx <= last_calc;
        end
      end
      S_RD0: begin
        lo_point <= rd_point;
        lo_value <= rd_value;
      end
      S_RDL: begin
        hi_point <= rd_point;
        hi_value <= rd_value;
        idx      <= AW'(1);
        if (q_lt_lo) begin
          res_region <= REGION_BELOW;
        end else if (q_gt_rd) begin
          res_region <= REGION_ABOVE;
        end else begin
          res_region <= REGION_INSIDE;
        end
      end
      S_BELOW: begin
        hi_point  <= rd_point;
        hi_value  <= rd_value;
        anchor_hi <= 1'b0;
      end
      S_ABOVE: begin
        lo_point  <= rd_point;
        lo_value  <= rd_value;
        anchor_hi <= 1'b1;
      end
      S_SEARCH: begin
        if (q_lt_rd) begin
          hi_point  <= rd_point;
          hi_value  <= rd_value;
          anchor_hi <= 1'b0;
        end else if (idx == last_idx) begin
          // query sits on the last point
          res_value <= rd_value;
          res_sat   <= 1'b0;
        end else begin
          lo_point <= rd_point;
          lo_value <= rd_value;
          idx      <= idx + AW'(1);
        end
      end
      S_ARITH: begin
        if (arith_rsp.done) begin
          res_value <= arith_value;
          res_sat   <= arith_rsp.sat;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      interp_value <= res_value;
      region       <= res_region;
      saturated    <= res_sat;
    end
  end

  assign arith_req = '{start: (state == S_START), anchor_hi: anchor_hi};

endmodule

`default_nettype wire

FILE: test/piecewise_linear_table_interp_top_test.sv
`timescale 1ns / 100ps

localparam longint Q_MIN = -64'sd2147483648;
localparam longint Q_MAX = 64'sd2147483647;
localparam logic [31:0] VALUE_MIN = 32'h8000_0000;
localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;

typedef struct packed {
  logic [31:0] value;
  logic [1:0]  region;
  logic        sat;
} interp_result_t;

class interp_scoreboard;
  logic signed [31:0] points [256];
  logic signed [31:0] values [256];
  int active_count = 256;
  interp_result_t expected_results [$];
  int errors = 0;

  function void set_samples(logic [8:0] setting);
    active_count = (setting < 2) ? 2 : (setting > 256) ? 256 : setting;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  // anchor + dy*dq/dx, quotient truncated toward zero, clipped to 32 bits
  function interp_result_t segment_result(logic signed [31:0] anchor, y1, y0, q, pa, x1, x0);
    interp_result_t r;
    longint dy, dq, dx, total;
    longint unsigned ady, adq, adx, offset;
    bit neg;
    dy = longint'(y1) - longint'(y0);
    dq = longint'(q) - longint'(pa);
    dx = longint'(x1) - longint'(x0);
    r.value = anchor;
    r.region = plti_pkg::REGION_INSIDE;
    r.sat = 1'b0;
    if (dx == 0) return r;
    neg = (dy < 0) ^ (dq < 0) ^ (dx < 0);
    ady = (dy < 0) ? -dy : dy;
    adq = (dq < 0) ? -dq : dq;
    adx = (dx < 0) ? -dx : dx;
    offset = ady * adq / adx;
    if (offset > 64'h1_0000_0000) total = neg ? Q_MIN - 1 : Q_MAX + 1;
    else total = longint'(anchor) + (neg ? -longint'(offset) : longint'(offset));
    if (total > Q_MAX) begin
      r.value = VALUE_MAX;
      r.sat = 1'b1;
    end else if (total < Q_MIN) begin
      r.value = VALUE_MIN;
      r.sat = 1'b1;
    end else begin
      r.value = total[31:0];
    end
    return r;
  endfunction

  function interp_result_t evaluate_at(logic signed [31:0] q);
    interp_result_t r;
    int last, i;
    last = active_count - 1;
    if (q < points[0]) begin
      r = segment_result(values[0], values[1], values[0], q, points[0], points[1], points[0]);
      r.region = plti_pkg::REGION_BELOW;
    end else if (q > points[last]) begin
      r = segment_result(values[last], values[last], values[last-1], q,
                         points[last], points[last], points[last-1]);
      r.region = plti_pkg::REGION_ABOVE;
    end else begin
      // q equal to the last point falls through the scan
      r.value = values[last];
      r.sat = 1'b0;
      r.region = plti_pkg::REGION_INSIDE;
      for (i = 1; i < active_count; i++) begin
        if (q < points[i]) begin
          r = segment_result(values[i-1], values[i], values[i-1], q,
                             points[i-1], points[i], points[i-1]);
          break;
        end
      end
    end
    return r;
  endfunction

  function void note_input(logic k, logic [7:0] idx, logic [31:0] pt, val, q);
    if (k == plti_pkg::KIND_LOAD) begin
      points[idx] = pt;
      values[idx] = val;
    end else begin
      expected_results.push_back(evaluate_at(q));
    end
  endfunction

  task report(string msg);
    if (errors < 100) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task check_result(logic [31:0] value, logic [1:0] region, logic sat);
    interp_result_t want;
    if (expected_results.size() == 0) begin
      report($sformatf("result %h region %0d sat %b with nothing outstanding",
                       value, region, sat));
      return;
    end
    want = expected_results.pop_front();
    if (value !== want.value || region !== want.region || sat !== want.sat)
      report($sformatf("got value %h region %0d sat %b, want value %h region %0d sat %b",
                       value, region, sat, want.value, want.region, want.sat));
  endtask
endclass

module piecewise_linear_table_interp_top_test;
  localparam int ITEM_TARGET = 1900;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [8:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  wire in_ready;
  logic kind = plti_pkg::KIND_LOAD;
  logic [7:0] entry_index = '0;
  logic [31:0] sample_point = '0;
  logic [31:0] sample_value = '0;
  logic [31:0] query_point = '0;
  wire out_valid;
  logic out_ready = 1'b0;
  wire [31:0] interp_value;
  wire [1:0] region;
  wire saturated;

  interp_scoreboard sb = new;
  bit steady = 1'b0;
  int items_accepted = 0;
  int fresh_span = 0;
  logic [8:0] phase_settings [11] = '{9'd0, 9'd256, 9'd511, 9'd300, 9'd1, 9'd12,
                                      9'd3, 9'd40, 9'd2, 9'd100, 9'd5};

  piecewise_linear_table_interp_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .entry_index(entry_index),
    .sample_point(sample_point),
    .sample_value(sample_value),
    .query_point(query_point),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .interp_value(interp_value),
    .region(region),
    .saturated(saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(interp_value, region, saturated);
  end

  function automatic longint rand_between(input longint lo, input longint hi);
    longint unsigned r;
    r = {$urandom, $urandom};
    return lo + longint'(r % longint'(hi - lo + 1));
  endfunction

  // valid stays high across back-to-back transactions; lowered only for a gap
  task automatic send_item(input logic k, input logic [7:0] idx, input logic [31:0] pt,
                           input logic [31:0] val, input logic [31:0] q);
    if (!steady && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 60);
    end
    kind <= k;
    entry_index <= idx;
    sample_point <= pt;
    sample_value <= val;
    query_point <= q;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(k, idx, pt, val, q);
    items_accepted++;
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [31:0] pt,
                            input logic [31:0] val);
    send_item(plti_pkg::KIND_LOAD, idx, pt, val, $urandom);
  endtask

  task automatic ask_at(input logic [31:0] q);
    send_item(plti_pkg::KIND_QUERY, $urandom, $urandom, $urandom, q);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_samples(input logic [8:0] setting);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= setting;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_samples(setting);
  endtask

  task automatic run_table_phase(input logic [8:0] setting);
    logic signed [31:0] pts [256];
    int n, e, sh, start_at, k, r;
    longint p, lo, hi, bound;
    logic [31:0] q;
    bit ordered;
    write_samples(setting);
    n = sb.active_count;
    // a full-size table loaded in the previous phase is kept
    if (!(n == 256 && fresh_span == 256)) begin
      ordered = $urandom_range(0, 3) != 0;
      e = $urandom_range(0, 23);
      sh = $urandom_range(0, 24);
      p = ($urandom_range(0, 7) == 0) ? Q_MIN : -((longint'(n) << e) >>> 1);
      for (k = 0; k < n; k++) begin
        pts[k] = ordered ? p[31:0] : $urandom;
        if ($urandom_range(0, 9) != 0) p += rand_between(1, longint'(1) << e);
      end
      start_at = $urandom_range(0, n - 1);
      for (k = 0; k < n; k++)
        load_entry((start_at + k) % n, pts[(start_at + k) % n], $signed($urandom) >>> sh);
      fresh_span = n;
    end
    for (k = 0; k < 60; k++) begin
      lo = sb.points[0];
      hi = sb.points[n-1];
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // stray load: past the active span, or corrupting the ordering
        load_entry($urandom, $urandom, $urandom);
      end else begin
        if (r < 16) begin
          q = sb.points[$urandom_range(0, n - 1)];
        end else if (r < 32) begin
          if (lo == Q_MIN) begin
            q = $urandom;
          end else begin
            bound = $urandom_range(0, 1) ? Q_MIN : lo - 4096;
            if (bound < Q_MIN) bound = Q_MIN;
            q = rand_between(bound, lo - 1);
          end
        end else if (r < 48) begin
          if (hi == Q_MAX) begin
            q = $urandom;
          end else begin
            bound = $urandom_range(0, 1) ? Q_MAX : hi + 4096;
            if (bound > Q_MAX) bound = Q_MAX;
            q = rand_between(hi + 1, bound);
          end
        end else begin
          q = (lo <= hi) ? rand_between(lo, hi) : $urandom;
        end
        ask_at(q);
      end
    end
  endtask

  initial begin
    int phase;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_samples(9'd2);

    // slope of two through the origin
    load_entry(8'd0, 32'h0, 32'h0);
    load_entry(8'd1, ONE, 2 * ONE);
    ask_at(32'h0);
    ask_at(32'h0000_8000);
    ask_at(ONE);
    ask_at(-ONE);
    ask_at(32'h0003_0000);
    ask_at(VALUE_MAX);
    ask_at(VALUE_MIN);
    // full-range segment, falling
    load_entry(8'd0, VALUE_MIN, VALUE_MAX);
    load_entry(8'd1, VALUE_MAX, VALUE_MIN);
    ask_at(32'h0);
    ask_at(VALUE_MIN);
    ask_at(VALUE_MAX);
    // zero-width segment
    load_entry(8'd0, 32'h0005_0000, 32'h0001_2345);
    load_entry(8'd1, 32'h0005_0000, 32'hFFFF_FFFB);
    ask_at(32'h0004_0000);
    ask_at(32'h0006_0000);
    ask_at(32'h0005_0000);
    // descending points
    load_entry(8'd0, ONE, 32'h0003_0000);
    load_entry(8'd1, -ONE, ONE);
    ask_at(32'h0);
    ask_at(32'h0002_0000);

    phase = 0;
    while (items_accepted < ITEM_TARGET) begin
      steady = (phase % 5 == 3);
      if (phase < 11) run_table_phase(phase_settings[phase]);
      else if ($urandom_range(0, 5) == 0) run_table_phase($urandom_range(25, 120));
      else run_table_phase($urandom_range(2, 24));
      phase++;
    end
    steady = 1'b0;

    settle();
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("piecewise_linear_table_interp_top_test: done, clean");
    end else begin
      $display("piecewise_linear_table_interp_top_test: done, errors");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("piecewise_linear_table_interp_top_test: done, errors");
    $finish;
  end
endmodule

FILE: sim.f
hdl/plti_pkg.sv
hdl/plti_mem.sv
hdl/plti_arith.sv
hdl/plti_ctrl.sv
hdl/piecewise_linear_table_interp_top.sv
test/piecewise_linear_table_interp_top_test.sv
